>>> rtl/mef_pkg.sv
// ============================================================================
// mef_pkg: shared types and constants of the master election unit
// Time width, register map, receive status codes, queue item layout and
// the saturating time helper used by front and back.
// ============================================================================
package mef_pkg;

    // Time arithmetic
    localparam int TIME_BITS = 64;
    localparam int SPAN_BITS = 48;
    localparam int SUM_BITS  = ((TIME_BITS > SPAN_BITS) ? TIME_BITS : SPAN_BITS) + 2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SUM_BITS-1:0]  tsum_t;

    localparam time_t TMASK = {TIME_BITS{1'b1}};

    // Configuration port
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_OWN_PRIORITY    = 3'd0,
        REG_OWN_SOURCE      = 3'd1,
        REG_ANNOUNCE_PERIOD = 3'd2,
        REG_DEAD_PERIODS    = 3'd3,
        REG_EXPIRY_SKEW     = 3'd4,
        REG_STARTUP_DELAY   = 3'd5,
        REG_NOTIFY_INTERVAL = 3'd6
    } reg_index_t;

    localparam logic [31:0] OWN_PRIORITY_RST    = 32'd1;
    localparam logic [31:0] OWN_SOURCE_RST      = 32'd0;
    localparam logic [31:0] ANNOUNCE_PERIOD_RST = 32'd5400000;
    localparam logic [15:0] DEAD_PERIODS_RST    = 16'd5;
    localparam logic [31:0] EXPIRY_SKEW_RST     = 32'd0;
    localparam logic [31:0] STARTUP_DELAY_RST   = 32'd0;
    localparam logic [31:0] NOTIFY_INTERVAL_RST = 32'd27000000;
    localparam logic [SPAN_BITS-1:0] DEAD_SPAN_RST = SPAN_BITS'(27000000);

    typedef struct packed {
        logic [31:0]          own_priority;
        logic [31:0]          own_source;
        logic [31:0]          announce_period;
        logic [15:0]          dead_periods;
        logic [31:0]          expiry_skew;
        logic [31:0]          startup_delay;
        logic [31:0]          notify_interval;
        logic [SPAN_BITS-1:0] dead_span;
    } cfg_t;

    // Message format
    localparam logic [3:0]  ANNOUNCE_BYTES   = 4'd12;
    localparam logic [31:0] RX_VERSION_MAX   = 32'd2;
    localparam logic [1:0]  TX_VER_NONE      = 2'd0;
    localparam logic [1:0]  TX_VER_ANNOUNCE  = 2'd1;
    localparam logic [1:0]  TX_VER_NOTIFY    = 2'd2;

    typedef enum logic [2:0] {
        RX_NONE        = 3'd0,
        RX_OK          = 3'd1,
        RX_SHORT       = 3'd2,
        RX_BAD_VERSION = 3'd3,
        RX_OWN_SOURCE  = 3'd4
    } rx_status_t;

    typedef enum logic [1:0] {
        PRIO_ZERO   = 2'd0,
        PRIO_LOWER  = 2'd1,
        PRIO_HIGHER = 2'd2
    } prio_class_t;

    typedef enum logic {
        ROLE_BACKUP = 1'b0,
        ROLE_MASTER = 1'b1
    } role_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic        is_tick;
        logic        link_up;
        rx_status_t  status;
        prio_class_t prio_class;
        time_t       now;
        time_t       skew_t;     // now + expiry_skew
        time_t       period_t;   // now + announce_period
        time_t       notify_t;   // now + notify_interval, kept below all ones
        time_t       dead_t;     // now + dead span + expiry_skew
        time_t       full_t;     // dead_t + startup_delay
    } item_t;

    // Clamp a widened sum to the largest time
    function automatic time_t sat_time(input tsum_t s);
        time_t r;
        if (s > SUM_BITS'(TMASK))
            r = TMASK;
        else
            r = s[TIME_BITS-1:0];
        return r;
    endfunction

endpackage

>>> rtl/mef_cfg.sv
// ============================================================================
// mef_cfg: configuration registers
// APB-style register file with read back, plus the registered dead span
// (announce period times dead periods) used for deadline arithmetic.
// ============================================================================
module mef_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mef_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [mef_pkg::DATA_BITS-1:0]  pwdata,
    output logic [mef_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output mef_pkg::cfg_t                  cfg
);

    logic [31:0]                   own_priority_reg;
    logic [31:0]                   own_source_reg;
    logic [31:0]                   announce_period_reg;
    logic [15:0]                   dead_periods_reg;
    logic [31:0]                   expiry_skew_reg;
    logic [31:0]                   startup_delay_reg;
    logic [31:0]                   notify_interval_reg;
    logic [mef_pkg::SPAN_BITS-1:0] dead_span_reg;
    logic [mef_pkg::SPAN_BITS-1:0] dead_span_next;
    logic                          wr_en;
    mef_pkg::reg_index_t           index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = mef_pkg::reg_index_t'(paddr[4:2]);

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_priority_reg    <= mef_pkg::OWN_PRIORITY_RST;
            own_source_reg      <= mef_pkg::OWN_SOURCE_RST;
            announce_period_reg <= mef_pkg::ANNOUNCE_PERIOD_RST;
            dead_periods_reg    <= mef_pkg::DEAD_PERIODS_RST;
            expiry_skew_reg     <= mef_pkg::EXPIRY_SKEW_RST;
            startup_delay_reg   <= mef_pkg::STARTUP_DELAY_RST;
            notify_interval_reg <= mef_pkg::NOTIFY_INTERVAL_RST;
        end
        else if (wr_en)
        begin
            case (index)
                mef_pkg::REG_OWN_PRIORITY:    own_priority_reg    <= pwdata;
                mef_pkg::REG_OWN_SOURCE:      own_source_reg      <= pwdata;
                mef_pkg::REG_ANNOUNCE_PERIOD: announce_period_reg <= pwdata;
                mef_pkg::REG_DEAD_PERIODS:    dead_periods_reg    <= pwdata[15:0];
                mef_pkg::REG_EXPIRY_SKEW:     expiry_skew_reg     <= pwdata;
                mef_pkg::REG_STARTUP_DELAY:   startup_delay_reg   <= pwdata;
                mef_pkg::REG_NOTIFY_INTERVAL: notify_interval_reg <= pwdata;
                default:                      ;
            endcase
        end
    end

    // Register the dead span product in the cycle after the settings change
    assign dead_span_next = mef_pkg::SPAN_BITS'(announce_period_reg)
                            * mef_pkg::SPAN_BITS'(dead_periods_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dead_span_reg <= mef_pkg::DEAD_SPAN_RST;
        else
            dead_span_reg <= dead_span_next;
    end

    // Read back
    always_comb
    begin
        case (index)
            mef_pkg::REG_OWN_PRIORITY:    prdata = own_priority_reg;
            mef_pkg::REG_OWN_SOURCE:      prdata = own_source_reg;
            mef_pkg::REG_ANNOUNCE_PERIOD: prdata = announce_period_reg;
            mef_pkg::REG_DEAD_PERIODS:    prdata = {16'd0, dead_periods_reg};
            mef_pkg::REG_EXPIRY_SKEW:     prdata = expiry_skew_reg;
            mef_pkg::REG_STARTUP_DELAY:   prdata = startup_delay_reg;
            mef_pkg::REG_NOTIFY_INTERVAL: prdata = notify_interval_reg;
            default:                      prdata = '0;
        endcase
    end

    assign cfg.own_priority    = own_priority_reg;
    assign cfg.own_source      = own_source_reg;
    assign cfg.announce_period = announce_period_reg;
    assign cfg.dead_periods    = dead_periods_reg;
    assign cfg.expiry_skew     = expiry_skew_reg;
    assign cfg.startup_delay   = startup_delay_reg;
    assign cfg.notify_interval = notify_interval_reg;
    assign cfg.dead_span       = dead_span_reg;

endmodule

>>> rtl/mef_front.sv
// ============================================================================
// mef_front: request intake and classification
// Checks announces, classifies their priority and precomputes every
// candidate time a request may need, ready for the back end.
// ============================================================================
module mef_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mef_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [63:0]          now,
    input  logic                 link_up,
    input  logic [3:0]           rx_length,
    input  logic [31:0]          rx_version,
    input  logic [31:0]          rx_priority,
    input  logic [31:0]          rx_source,
    output logic                 push,
    output mef_pkg::item_t       item,
    input  logic                 q_ready
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_tick_reg;
    logic                  s1_up_reg;
    mef_pkg::rx_status_t   s1_status_reg;
    mef_pkg::prio_class_t  s1_class_reg;
    mef_pkg::time_t        s1_now_reg;
    mef_pkg::tsum_t        s1_skew_sum_reg;
    mef_pkg::time_t        s1_period_reg;
    mef_pkg::time_t        s1_notify_reg;

    mef_pkg::time_t        now_t;
    mef_pkg::rx_status_t   status_c;
    mef_pkg::prio_class_t  class_c;
    mef_pkg::time_t        notify_sat;
    logic                  accept;
    logic                  s1_ready;

    assign now_t    = now[mef_pkg::TIME_BITS-1:0];
    assign s1_ready = !s1_valid_reg || q_ready;
    assign in_stall = !s1_ready;
    assign accept   = in_valid && s1_ready;
    assign push     = s1_valid_reg && q_ready;

    // Check announce: length, then version, then own source
    always_comb
    begin
        if (!kind)
            status_c = mef_pkg::RX_NONE;
        else if (rx_length != mef_pkg::ANNOUNCE_BYTES)
            status_c = mef_pkg::RX_SHORT;
        else if (rx_version > mef_pkg::RX_VERSION_MAX)
            status_c = mef_pkg::RX_BAD_VERSION;
        else if (rx_source == cfg.own_source)
            status_c = mef_pkg::RX_OWN_SOURCE;
        else
            status_c = mef_pkg::RX_OK;
    end

    // Classify peer priority against ours
    always_comb
    begin
        if (rx_priority == 32'd0)
            class_c = mef_pkg::PRIO_ZERO;
        else if (rx_priority < cfg.own_priority)
            class_c = mef_pkg::PRIO_LOWER;
        else
            class_c = mef_pkg::PRIO_HIGHER;
    end

    // Notify time stays below all ones, which marks none pending
    always_comb
    begin
        notify_sat = mef_pkg::sat_time(mef_pkg::SUM_BITS'(now_t)
                                       + mef_pkg::SUM_BITS'(cfg.notify_interval));
        if (notify_sat == mef_pkg::TMASK)
            notify_sat = mef_pkg::TMASK - mef_pkg::TIME_BITS'(1);
    end

    assign s1_valid_next = accept || (s1_valid_reg && !q_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Capture request and first-level sums
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tick_reg     <= !kind;
            s1_up_reg       <= link_up;
            s1_status_reg   <= status_c;
            s1_class_reg    <= class_c;
            s1_now_reg      <= now_t;
            s1_skew_sum_reg <= mef_pkg::SUM_BITS'(now_t)
                               + mef_pkg::SUM_BITS'(cfg.expiry_skew);
            s1_period_reg   <= mef_pkg::sat_time(mef_pkg::SUM_BITS'(now_t)
                               + mef_pkg::SUM_BITS'(cfg.announce_period));
            s1_notify_reg   <= notify_sat;
        end
    end

    // Add the dead span and startup delay on the way to the queue
    always_comb
    begin
        item.is_tick    = s1_tick_reg;
        item.link_up    = s1_up_reg;
        item.status     = s1_status_reg;
        item.prio_class = s1_class_reg;
        item.now        = s1_now_reg;
        item.skew_t     = mef_pkg::sat_time(s1_skew_sum_reg);
        item.period_t   = s1_period_reg;
        item.notify_t   = s1_notify_reg;
        item.dead_t     = mef_pkg::sat_time(s1_skew_sum_reg
                                            + mef_pkg::SUM_BITS'(cfg.dead_span));
        item.full_t     = mef_pkg::sat_time(s1_skew_sum_reg
                                            + mef_pkg::SUM_BITS'(cfg.dead_span)
                                            + mef_pkg::SUM_BITS'(cfg.startup_delay));
    end

endmodule

>>> rtl/mef_queue.sv
// ============================================================================
// mef_queue: two-entry request queue
// Decouples the front end from the back end; accepts a push in the same
// cycle as a pop when full.
// ============================================================================
module mef_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mef_pkg::item_t  push_item,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output mef_pkg::item_t  head
);

    mef_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign q_valid = (count_reg != 2'd0);
    assign q_ready = (count_reg != 2'd2) || pop;
    assign head    = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed request
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> rtl/mef_back.sv
// ============================================================================
// mef_back: election state and result register
// Applies one classified request per cycle, when not stalled, to the role,
// deadline and message timers, and holds the result until it is taken.
// ============================================================================
module mef_back (
    input  logic            clk,
    input  logic            rst_n,
    input  mef_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  mef_pkg::item_t  head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            became_master,
    output logic            lost_master,
    output logic            is_master,
    output logic            send_message,
    output logic [1:0]      tx_version,
    output logic [31:0]     tx_priority,
    output logic [2:0]      rx_status,
    output logic [63:0]     next_wake
);

    // Election state
    mef_pkg::role_t  role_reg;
    mef_pkg::role_t  role_next;
    logic            armed_reg;
    mef_pkg::time_t  nat_reg;
    mef_pkg::time_t  nat_next;
    mef_pkg::time_t  dl_reg;
    mef_pkg::time_t  dl_next;
    mef_pkg::time_t  nnt_reg;
    mef_pkg::time_t  nnt_next;

    // Per-request intermediates
    mef_pkg::time_t  dl_cur;
    mef_pkg::time_t  nat_add;
    logic            takeover;
    logic            announce_due;
    logic            notify_due;

    // Result
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            became_reg;
    logic            became_next;
    logic            lost_reg;
    logic            lost_next;
    logic            master_reg;
    logic            send_reg;
    logic            send_next;
    logic [1:0]      txv_reg;
    logic [1:0]      txv_next;
    logic [31:0]     txp_reg;
    logic [31:0]     txp_next;
    logic [2:0]      status_reg;
    mef_pkg::time_t  wake_reg;
    mef_pkg::time_t  wake_next;

    assign pop            = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = pop || (out_valid_reg && out_stall);
    assign nat_add        = mef_pkg::sat_time(mef_pkg::SUM_BITS'(nat_reg)
                                              + mef_pkg::SUM_BITS'(cfg.announce_period));

    // Next state
    always_comb
    begin
        dl_cur       = armed_reg ? dl_reg : head.full_t;
        role_next    = role_reg;
        nat_next     = nat_reg;
        dl_next      = dl_cur;
        nnt_next     = nnt_reg;
        takeover     = 1'b0;
        announce_due = 1'b0;
        notify_due   = 1'b0;
        if (head.is_tick)
        begin
            if (!head.link_up)
            begin
                role_next = mef_pkg::ROLE_BACKUP;
                nat_next  = mef_pkg::TMASK;
                dl_next   = head.full_t;
            end
            else if (role_reg == mef_pkg::ROLE_BACKUP && dl_cur <= head.now)
            begin
                takeover  = 1'b1;
                role_next = mef_pkg::ROLE_MASTER;
                nat_next  = head.now;
            end
            if (role_next == mef_pkg::ROLE_MASTER)
            begin
                announce_due = takeover || (nat_reg <= head.now);
                if (announce_due)
                    nat_next = takeover ? head.period_t : nat_add;
                nnt_next = mef_pkg::TMASK;
            end
            else
            begin
                notify_due = (nnt_reg < head.now) || (nnt_reg == mef_pkg::TMASK);
                if (notify_due)
                    nnt_next = head.notify_t;
            end
        end
        else if (head.status == mef_pkg::RX_OK)
        begin
            case (head.prio_class)
                mef_pkg::PRIO_LOWER:
                begin
                    if (head.skew_t < dl_cur)
                        dl_next = head.skew_t;
                end
                mef_pkg::PRIO_HIGHER:
                begin
                    role_next = mef_pkg::ROLE_BACKUP;
                    nat_next  = mef_pkg::TMASK;
                    dl_next   = head.dead_t;
                end
                default: ;
            endcase
        end
    end

    // Outputs of the request
    always_comb
    begin
        became_next = (role_reg == mef_pkg::ROLE_BACKUP) && (role_next == mef_pkg::ROLE_MASTER);
        lost_next   = (role_reg == mef_pkg::ROLE_MASTER) && (role_next == mef_pkg::ROLE_BACKUP);
        send_next   = announce_due || notify_due;
        if (announce_due)
        begin
            txv_next = mef_pkg::TX_VER_ANNOUNCE;
            txp_next = cfg.own_priority;
        end
        else if (notify_due)
        begin
            txv_next = mef_pkg::TX_VER_NOTIFY;
            txp_next = 32'd0;
        end
        else
        begin
            txv_next = mef_pkg::TX_VER_NONE;
            txp_next = 32'd0;
        end
        wake_next = (role_next == mef_pkg::ROLE_MASTER) ? nat_next : dl_next;
        if (nnt_next < wake_next)
            wake_next = nnt_next;
    end

    // Update election state on each popped request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg  <= mef_pkg::ROLE_BACKUP;
            armed_reg <= 1'b0;
            nat_reg   <= mef_pkg::TMASK;
            dl_reg    <= '0;
            nnt_reg   <= mef_pkg::TMASK;
        end
        else if (pop)
        begin
            role_reg  <= role_next;
            armed_reg <= 1'b1;
            nat_reg   <= nat_next;
            dl_reg    <= dl_next;
            nnt_reg   <= nnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Load result register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            became_reg <= became_next;
            lost_reg   <= lost_next;
            master_reg <= (role_next == mef_pkg::ROLE_MASTER);
            send_reg   <= send_next;
            txv_reg    <= txv_next;
            txp_reg    <= txp_next;
            status_reg <= head.status;
            wake_reg   <= wake_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign became_master = became_reg;
    assign lost_master   = lost_reg;
    assign is_master     = master_reg;
    assign send_message  = send_reg;
    assign tx_version    = txv_reg;
    assign tx_priority   = txp_reg;
    assign rx_status     = status_reg;
    assign next_wake     = 64'(wake_reg);

`ifndef ASSERT_OFF
    a_became_is_master: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && became_reg |-> master_reg && !lost_reg)
        else $error("became_master without master role");

    a_lost_is_backup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && lost_reg |-> !master_reg)
        else $error("lost_master while still master");

    a_announce_from_master: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && send_reg && txv_reg == mef_pkg::TX_VER_ANNOUNCE |-> master_reg)
        else $error("announce sent by backup");

    a_no_send_on_rx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != mef_pkg::RX_NONE |-> !send_reg)
        else $error("message sent on a received announce");
`endif

endmodule

>>> rtl/master_election_fsm_unit.sv
// ============================================================================
// master_election_fsm_unit: master election engine
// Top level: configuration registers, request front end, queue and back end.
// ============================================================================
// Takes one request (time tick or received announce) per clock while
// in_stall is low and returns one result per request, in order. The intake
// stage checks and classifies the request and registers it at the accepting
// edge; the front end then adds the deadline sums and writes it into the
// two-entry queue, and the back end pops it, updates the election state and
// loads the result register. Sustained rate is one request per cycle while
// out_stall stays low; the back end's state update of role, deadline and
// timers for each popped request sets that rate. The dead span product is
// registered from the settings, so a request may follow a register write in
// the next cycle.
module master_election_fsm_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mef_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [mef_pkg::DATA_BITS-1:0]  pwdata,
    output logic [mef_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic [63:0]                    now,
    input  logic                           link_up,
    input  logic [3:0]                     rx_length,
    input  logic [31:0]                    rx_version,
    input  logic [31:0]                    rx_priority,
    input  logic [31:0]                    rx_source,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           became_master,
    output logic                           lost_master,
    output logic                           is_master,
    output logic                           send_message,
    output logic [1:0]                     tx_version,
    output logic [31:0]                    tx_priority,
    output logic [2:0]                     rx_status,
    output logic [63:0]                    next_wake
);

    mef_pkg::cfg_t  cfg;
    mef_pkg::item_t push_item;
    mef_pkg::item_t head;
    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;

    mef_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mef_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .now         (now),
        .link_up     (link_up),
        .rx_length   (rx_length),
        .rx_version  (rx_version),
        .rx_priority (rx_priority),
        .rx_source   (rx_source),
        .push        (push),
        .item        (push_item),
        .q_ready     (q_ready)
    );

    mef_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head)
    );

    mef_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .became_master (became_master),
        .lost_master   (lost_master),
        .is_master     (is_master),
        .send_message  (send_message),
        .tx_version    (tx_version),
        .tx_priority   (tx_priority),
        .rx_status     (rx_status),
        .next_wake     (next_wake)
    );

endmodule
